### sv/cacu_pkg.sv
// shared types, constants and codes of the complex arithmetic and compare unit
package cacu_pkg;

  // default number of fraction bits of the fixed-point format
  localparam int FRAC_BITS = 16;

  // quotient bits produced by the divider, and root bits produced by the square root
  localparam int NUM_ITER   = 33;
  localparam int SQRT_STEPS = 32;

  // operation codes
  localparam logic [2:0] KIND_ADD = 3'd0;
  localparam logic [2:0] KIND_SUB = 3'd1;
  localparam logic [2:0] KIND_MUL = 3'd2;
  localparam logic [2:0] KIND_DIV = 3'd3;
  localparam logic [2:0] KIND_CMP = 3'd4;

  // register port
  localparam int          ADDR_W        = 3;
  localparam logic        IDX_EPSILON   = 1'b0;
  localparam logic [15:0] EPSILON_RESET = 16'd66;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    logic               is_less;
    logic               is_equal;
    logic               is_greater;
    logic               div_zero;
    logic               saturated;
  } out_item_t;

  // one result part: sign and magnitude, plus divider state
  typedef struct packed {
    logic        neg;
    logic        ovf;
    logic [63:0] mag;
    logic [63:0] rem;
    logic [32:0] nlo;
    logic [32:0] quo;
  } lane_t;

  // square root state of one modulus
  typedef struct packed {
    logic [63:0] n;
    logic [35:0] rem;
    logic [31:0] root;
  } sqrt_t;

  // item travelling through the iteration stages
  typedef struct packed {
    logic [2:0]  kind;
    logic        dz;
    logic [63:0] d;
    lane_t       re;
    lane_t       im;
    sqrt_t       sa;
    sqrt_t       sb;
  } iter_t;

endpackage

### sv/cacu_iter_stage.sv
// iteration stage: restoring divide step on both parts, sqrt step on both moduli if SqrtStep
module cacu_iter_stage #(
  parameter bit SqrtStep = 1'b1
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  cacu_pkg::iter_t item_i,
  output cacu_pkg::iter_t item_o
);

  cacu_pkg::iter_t item_d, item_q;

  // one quotient bit
  function automatic cacu_pkg::lane_t div_step(input cacu_pkg::lane_t l, input logic [63:0] d);
    cacu_pkg::lane_t r;
    logic [63:0] sh;
    logic [64:0] diff;
    r    = l;
    sh   = {l.rem[62:0], l.nlo[32]};
    diff = {1'b0, sh} - {1'b0, d};
    r.nlo = {l.nlo[31:0], 1'b0};
    if (!diff[64]) begin
      r.rem = diff[63:0];
      r.quo = {l.quo[31:0], 1'b1};
    end else begin
      r.rem = sh;
      r.quo = {l.quo[31:0], 1'b0};
    end
    return r;
  endfunction

  // one root bit
  function automatic cacu_pkg::sqrt_t sqrt_step(input cacu_pkg::sqrt_t s);
    cacu_pkg::sqrt_t r;
    logic [35:0] cur;
    logic [35:0] trial;
    logic [36:0] diff;
    r     = s;
    cur   = {s.rem[33:0], s.n[63:62]};
    trial = {2'b00, s.root, 2'b01};
    diff  = {1'b0, cur} - {1'b0, trial};
    r.n   = {s.n[61:0], 2'b00};
    if (!diff[36]) begin
      r.rem  = diff[35:0];
      r.root = {s.root[30:0], 1'b1};
    end else begin
      r.rem  = cur;
      r.root = {s.root[30:0], 1'b0};
    end
    return r;
  endfunction

  // step logic
  always_comb begin
    item_d    = item_i;
    item_d.re = div_step(item_i.re, item_i.d);
    item_d.im = div_step(item_i.im, item_i.d);
    if (SqrtStep) begin
      item_d.sa = sqrt_step(item_i.sa);
      item_d.sb = sqrt_step(item_i.sb);
    end
  end

  // stage register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

### sv/complex_arith_compare_unit_core.sv
// Complex add, subtract, multiply, divide and modulus compare in signed fixed point.
// Throughput: one item per cycle while the output drains; 39 register stages, set by the 33 divide steps.
// Stalls hold only full stages; a bubble anywhere lets the stages before it advance.
// Reset clears all valid bits and sets epsilon to 66; no clearing pass is needed.
module complex_arith_compare_unit_core #(
  parameter int FracBits = cacu_pkg::FRAC_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  cacu_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output cacu_pkg::out_item_t           out_item_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cacu_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int ShR    = 33 - FracBits;
  localparam int NumPre = 5;
  localparam int NStg   = NumPre + cacu_pkg::NUM_ITER + 1;
  localparam int OutStg = NStg - 1;

  typedef struct packed {
    logic [2:0]  kind;
    logic [32:0] add_re;
    logic [32:0] add_im;
    logic [63:0] p_rr;
    logic [63:0] p_ii;
    logic [63:0] p_ri;
    logic [63:0] p_ir;
    logic [63:0] q_ar;
    logic [63:0] q_ai;
    logic [63:0] q_br;
    logic [63:0] q_bi;
  } s1_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [64:0] sum_re;
    logic [64:0] sum_im;
    logic [63:0] d;
    logic [63:0] na;
  } s2_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic        neg_re;
    logic [63:0] mag_re;
    logic        neg_im;
    logic [63:0] mag_im;
    logic [63:0] d;
    logic [63:0] na;
    logic        dz;
  } s3_t;

  logic [NStg-1:0]     vld_q;
  logic [NStg-1:0]     en;
  logic [15:0]         eps_q;
  cacu_pkg::in_item_t  s0_q;
  s1_t                 s1_d, s1_q;
  s2_t                 s2_d, s2_q;
  s3_t                 s3_d, s3_q;
  cacu_pkg::iter_t     s4_d, s4_q;
  cacu_pkg::iter_t     it_out [cacu_pkg::NUM_ITER];
  cacu_pkg::out_item_t out_d, out_q;

  logic signed [31:0] ar, ai, br, bi;
  logic signed [63:0] m_rr, m_ii, m_ri, m_ir, m_aa, m_ai, m_bb, m_bi;

  // saturate a sign-magnitude value to 32 bits, flag in the top bit
  function automatic logic [32:0] clamp32(input logic neg, input logic [63:0] mag);
    logic [31:0] v;
    logic        sat;
    sat = 1'b0;
    if (neg) begin
      if (mag > 64'h0000_0000_8000_0000) begin
        v   = 32'h8000_0000;
        sat = 1'b1;
      end else begin
        v = 32'd0 - mag[31:0];
      end
    end else begin
      if (mag > 64'h0000_0000_7FFF_FFFF) begin
        v   = 32'h7FFF_FFFF;
        sat = 1'b1;
      end else begin
        v = mag[31:0];
      end
    end
    return {sat, v};
  endfunction

  // stage enables: a stage moves when the output drains or a bubble lies at or after it
  always_comb begin
    for (int k = 0; k < NStg; k++) begin
      en[k] = out_ready_i || (|((~vld_q) >> k));
    end
  end

  assign in_ready_o = en[0];

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NStg; k++) begin
        if (en[k]) begin
          vld_q[k] <= (k == 0) ? in_valid_i : vld_q[k-1];
        end
      end
    end
  end

  // epsilon register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= cacu_pkg::EPSILON_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == cacu_pkg::IDX_EPSILON)) begin
      eps_q <= pwdata[15:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == cacu_pkg::IDX_EPSILON) ? {16'd0, eps_q} : 32'd0;

  // input register
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s0_q <= in_item_i;
    end
  end

  // stage 1: multipliers and add/subtract
  assign ar = s0_q.a_re;
  assign ai = s0_q.a_im;
  assign br = s0_q.b_re;
  assign bi = s0_q.b_im;
  assign m_rr = ar * br;
  assign m_ii = ai * bi;
  assign m_ri = ar * bi;
  assign m_ir = ai * br;
  assign m_aa = ar * ar;
  assign m_ai = ai * ai;
  assign m_bb = br * br;
  assign m_bi = bi * bi;

  always_comb begin
    s1_d.kind = s0_q.kind;
    if (s0_q.kind == cacu_pkg::KIND_SUB) begin
      s1_d.add_re = {ar[31], ar} - {br[31], br};
      s1_d.add_im = {ai[31], ai} - {bi[31], bi};
    end else begin
      s1_d.add_re = {ar[31], ar} + {br[31], br};
      s1_d.add_im = {ai[31], ai} + {bi[31], bi};
    end
    s1_d.p_rr = m_rr;
    s1_d.p_ii = m_ii;
    s1_d.p_ri = m_ri;
    s1_d.p_ir = m_ir;
    s1_d.q_ar = m_aa;
    s1_d.q_ai = m_ai;
    s1_d.q_br = m_bb;
    s1_d.q_bi = m_bi;
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_q <= s1_d;
    end
  end

  // stage 2: cross sums, divisor and squared moduli
  always_comb begin
    logic [64:0] rr, ii, ri, ir;
    rr = {s1_q.p_rr[63], s1_q.p_rr};
    ii = {s1_q.p_ii[63], s1_q.p_ii};
    ri = {s1_q.p_ri[63], s1_q.p_ri};
    ir = {s1_q.p_ir[63], s1_q.p_ir};
    s2_d.kind = s1_q.kind;
    unique case (s1_q.kind)
      cacu_pkg::KIND_ADD, cacu_pkg::KIND_SUB: begin
        s2_d.sum_re = {{32{s1_q.add_re[32]}}, s1_q.add_re};
        s2_d.sum_im = {{32{s1_q.add_im[32]}}, s1_q.add_im};
      end
      cacu_pkg::KIND_MUL: begin
        s2_d.sum_re = rr - ii;
        s2_d.sum_im = ri + ir;
      end
      cacu_pkg::KIND_DIV: begin
        s2_d.sum_re = rr + ii;
        s2_d.sum_im = ir - ri;
      end
      default: begin
        s2_d.sum_re = '0;
        s2_d.sum_im = '0;
      end
    endcase
    s2_d.d  = s1_q.q_br + s1_q.q_bi;
    s2_d.na = s1_q.q_ar + s1_q.q_ai;
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_q <= s2_d;
    end
  end

  // stage 3: magnitudes, product scaling, zero divisor
  always_comb begin
    logic [64:0] abs_re, abs_im;
    abs_re = s2_q.sum_re[64] ? (65'd0 - s2_q.sum_re) : s2_q.sum_re;
    abs_im = s2_q.sum_im[64] ? (65'd0 - s2_q.sum_im) : s2_q.sum_im;
    s3_d.kind   = s2_q.kind;
    s3_d.neg_re = s2_q.sum_re[64];
    s3_d.neg_im = s2_q.sum_im[64];
    if (s2_q.kind == cacu_pkg::KIND_MUL) begin
      s3_d.mag_re = abs_re[63:0] >> FracBits;
      s3_d.mag_im = abs_im[63:0] >> FracBits;
    end else begin
      s3_d.mag_re = abs_re[63:0];
      s3_d.mag_im = abs_im[63:0];
    end
    s3_d.d  = s2_q.d;
    s3_d.na = s2_q.na;
    s3_d.dz = (s2_q.d == 64'd0);
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s3_q <= s3_d;
    end
  end

  // stage 4: divider and square root setup, quotient range check
  always_comb begin
    logic [63:0] r0_re, r0_im;
    r0_re = s3_q.mag_re >> ShR;
    r0_im = s3_q.mag_im >> ShR;
    s4_d.kind    = s3_q.kind;
    s4_d.dz      = s3_q.dz;
    s4_d.d       = s3_q.d;
    s4_d.re.neg  = s3_q.neg_re;
    s4_d.re.mag  = s3_q.mag_re;
    s4_d.re.rem  = r0_re;
    s4_d.re.ovf  = (r0_re >= s3_q.d);
    s4_d.re.nlo  = 33'(s3_q.mag_re << FracBits);
    s4_d.re.quo  = '0;
    s4_d.im.neg  = s3_q.neg_im;
    s4_d.im.mag  = s3_q.mag_im;
    s4_d.im.rem  = r0_im;
    s4_d.im.ovf  = (r0_im >= s3_q.d);
    s4_d.im.nlo  = 33'(s3_q.mag_im << FracBits);
    s4_d.im.quo  = '0;
    s4_d.sa.n    = s3_q.na;
    s4_d.sa.rem  = '0;
    s4_d.sa.root = '0;
    s4_d.sb.n    = s3_q.d;
    s4_d.sb.rem  = '0;
    s4_d.sb.root = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s4_q <= s4_d;
    end
  end

  // iteration stages
  for (genvar g = 0; g < cacu_pkg::NUM_ITER; g++) begin : g_iter
    cacu_iter_stage #(
      .SqrtStep(g < cacu_pkg::SQRT_STEPS)
    ) u_stage (
      .clk_i (clk_i),
      .en_i  (en[NumPre+g]),
      .item_i((g == 0) ? s4_q : it_out[(g == 0) ? 0 : g-1]),
      .item_o(it_out[g])
    );
  end

  // final stage: saturation, divide result and modulus compare
  always_comb begin
    cacu_pkg::iter_t l;
    logic [32:0] cre, cim;
    logic [63:0] qre, qim;
    logic [32:0] diff, absd;
    logic [33:0] tsum;
    l    = it_out[cacu_pkg::NUM_ITER-1];
    qre  = l.re.ovf ? 64'h0000_0001_0000_0000 : {31'd0, l.re.quo};
    qim  = l.im.ovf ? 64'h0000_0001_0000_0000 : {31'd0, l.im.quo};
    diff = {1'b0, l.sa.root} - {1'b0, l.sb.root};
    absd = diff[32] ? (33'd0 - diff) : diff;
    tsum = {diff[32], diff} + {18'd0, eps_q};
    out_d = '0;
    unique case (l.kind)
      cacu_pkg::KIND_ADD, cacu_pkg::KIND_SUB, cacu_pkg::KIND_MUL: begin
        cre = clamp32(l.re.neg, l.re.mag);
        cim = clamp32(l.im.neg, l.im.mag);
        out_d.res_re    = cre[31:0];
        out_d.res_im    = cim[31:0];
        out_d.saturated = cre[32] | cim[32];
      end
      cacu_pkg::KIND_DIV: begin
        cre = clamp32(l.re.neg, qre);
        cim = clamp32(l.im.neg, qim);
        if (l.dz) begin
          out_d.div_zero = 1'b1;
        end else begin
          out_d.res_re    = cre[31:0];
          out_d.res_im    = cim[31:0];
          out_d.saturated = cre[32] | cim[32];
        end
      end
      cacu_pkg::KIND_CMP: begin
        cre = '0;
        cim = '0;
        out_d.is_equal   = (absd < {17'd0, eps_q});
        out_d.is_less    = tsum[33];
        out_d.is_greater = !(absd < {17'd0, eps_q}) && !tsum[33];
      end
      default: begin
        cre = '0;
        cim = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[OutStg]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = vld_q[OutStg];
  assign out_item_o  = out_q;

endmodule

### tb/sv/tb_complex_arith_compare_unit_core.sv
// testbench for the complex arithmetic and modulus compare unit, self-checking
module tb_complex_arith_compare_unit_core;
  timeunit 1ns;
  timeprecision 1ps;

  // predicts each result and holds the ones still to come
  class cacu_result_book;
    cacu_pkg::out_item_t expected_results[$];
    logic [15:0]         epsilon;
    int                  mismatches;

    function new();
      epsilon = cacu_pkg::EPSILON_RESET;
      mismatches = 0;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %h, want %h at %0t", what, got, want, $realtime);
      mismatches++;
    endtask

    // clamp a sign and magnitude into 32 bits
    function logic [31:0] clamp32(bit neg, logic [79:0] m, inout bit sat);
      if (neg) begin
        if (m > 80'h8000_0000) begin
          m = 80'h8000_0000;
          sat = 1'b1;
        end
        return 32'(-m);
      end
      if (m > 80'h7fff_ffff) begin
        m = 80'h7fff_ffff;
        sat = 1'b1;
      end
      return m[31:0];
    endfunction

    // floor square root, two bits of the radicand per step
    function logic [63:0] floor_sqrt(logic [63:0] n);
      logic [63:0] root, bitv;
      root = '0;
      bitv = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
        if (n >= root + bitv) begin
          n = n - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      return root;
    endfunction

    // quotient of one part, capped just above the 32-bit range
    function logic [79:0] part_quotient(logic [65:0] mag, logic [65:0] d);
      logic [79:0] q;
      q = {mag[63:0], 16'b0} / {14'b0, d};
      return (q >= 80'h1_0000_0000) ? 80'h1_0000_0000 : q;
    endfunction

    // work out the result of one accepted item
    function void note(cacu_pkg::in_item_t it);
      logic signed [65:0] ar, ai, br, bi, s, d;
      logic signed [63:0] ma, mb, diff, e;
      cacu_pkg::out_item_t r;
      bit sat;
      ar = 66'(it.a_re);
      ai = 66'(it.a_im);
      br = 66'(it.b_re);
      bi = 66'(it.b_im);
      r = '0;
      sat = 1'b0;
      case (it.kind)
        cacu_pkg::KIND_ADD, cacu_pkg::KIND_SUB: begin
          s = (it.kind == cacu_pkg::KIND_ADD) ? ar + br : ar - br;
          r.res_re = clamp32(s < 0, 80'(s < 0 ? -s : s), sat);
          s = (it.kind == cacu_pkg::KIND_ADD) ? ai + bi : ai - bi;
          r.res_im = clamp32(s < 0, 80'(s < 0 ? -s : s), sat);
        end
        cacu_pkg::KIND_MUL: begin
          s = ar * br - ai * bi;
          r.res_re = clamp32(s < 0, 80'(s < 0 ? -s : s) >> cacu_pkg::FRAC_BITS, sat);
          s = ar * bi + ai * br;
          r.res_im = clamp32(s < 0, 80'(s < 0 ? -s : s) >> cacu_pkg::FRAC_BITS, sat);
        end
        cacu_pkg::KIND_DIV: begin
          d = br * br + bi * bi;
          if (d == 0) begin
            r.div_zero = 1'b1;
          end else begin
            s = ar * br + ai * bi;
            r.res_re = clamp32(s < 0, part_quotient(s < 0 ? -s : s, d), sat);
            s = ai * br - ar * bi;
            r.res_im = clamp32(s < 0, part_quotient(s < 0 ? -s : s, d), sat);
          end
        end
        cacu_pkg::KIND_CMP: begin
          s = ar * ar + ai * ai;
          ma = floor_sqrt(s[63:0]);
          s = br * br + bi * bi;
          mb = floor_sqrt(s[63:0]);
          diff = ma - mb;
          e = 64'(epsilon);
          r.is_equal = ((diff < 0) ? -diff : diff) < e;
          r.is_less = diff < -e;
          r.is_greater = !r.is_equal && !r.is_less;
        end
        default: ;
      endcase
      r.saturated = sat;
      expected_results.push_back(r);
    endfunction

    // compare one result with the oldest expectation
    task check(cacu_pkg::out_item_t got);
      cacu_pkg::out_item_t w;
      if (expected_results.size() == 0) begin
        report("unexpected result", 32'(got), 32'h0);
        return;
      end
      w = expected_results.pop_front();
      if (got.res_re !== w.res_re) report("res_re", got.res_re, w.res_re);
      if (got.res_im !== w.res_im) report("res_im", got.res_im, w.res_im);
      if (got.is_less !== w.is_less)
        report("is_less", 32'(got.is_less), 32'(w.is_less));
      if (got.is_equal !== w.is_equal)
        report("is_equal", 32'(got.is_equal), 32'(w.is_equal));
      if (got.is_greater !== w.is_greater)
        report("is_greater", 32'(got.is_greater), 32'(w.is_greater));
      if (got.div_zero !== w.div_zero)
        report("div_zero", 32'(got.div_zero), 32'(w.div_zero));
      if (got.saturated !== w.saturated)
        report("saturated", 32'(got.saturated), 32'(w.saturated));
    endtask
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  cacu_pkg::in_item_t            in_item_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  cacu_pkg::out_item_t           out_item_o;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [cacu_pkg::ADDR_W-1:0]   paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  cacu_result_book book = new();
  int in_idle_pct = 0;
  int out_idle_pct = 0;

  complex_arith_compare_unit_core dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side: check accepted items, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) book.check(out_item_o);
    out_ready_i <= rst_ni && ($urandom_range(99) >= out_idle_pct);
  end

  // send one item, with random gaps before it
  task send_item(cacu_pkg::in_item_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    book.note(it);
  endtask

  // let everything in flight come out
  task drain();
    in_valid_i <= 1'b0;
    while (book.expected_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  // register write: setup cycle, then access cycle
  task write_epsilon(logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= cacu_pkg::ADDR_W'(4 * cacu_pkg::IDX_EPSILON);
    pwdata <= {16'b0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    book.epsilon = value;
  endtask

  // one operand part: full range, small values or extremes
  function logic [31:0] rand_part();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3, 4, 5: return 32'($signed($urandom_range(0, 32'h003f_ffff)) - 32'sh0020_0000);
      default: return $urandom;
    endcase
  endfunction

  function cacu_pkg::in_item_t rand_item();
    cacu_pkg::in_item_t it;
    int r;
    r = $urandom_range(99);
    it.kind = (r < 6) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(cacu_pkg::KIND_CMP));
    it.a_re = rand_part();
    it.a_im = rand_part();
    it.b_re = rand_part();
    it.b_im = rand_part();
    // moduli often near each other: swap or negate parts, then sometimes nudge
    if (it.kind == cacu_pkg::KIND_CMP && $urandom_range(1)) begin
      it.b_re = $urandom_range(1) ? -it.a_im : it.a_re;
      it.b_im = $urandom_range(1) ? it.a_re : -it.a_im;
      if ($urandom_range(1)) it.b_re = it.b_re + 32'($signed($urandom_range(0, 200)) - 100);
    end
    if (it.kind == cacu_pkg::KIND_DIV && $urandom_range(9) == 0) begin
      it.b_re = '0;
      it.b_im = '0;
    end
    return it;
  endfunction

  function cacu_pkg::in_item_t mk(logic [2:0] k, logic [31:0] ar, logic [31:0] ai,
                                  logic [31:0] br, logic [31:0] bi);
    cacu_pkg::in_item_t it;
    it.kind = k;
    it.a_re = ar;
    it.a_im = ai;
    it.b_re = br;
    it.b_im = bi;
    return it;
  endfunction

  initial begin
    cacu_pkg::in_item_t directed[$];
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed items: extremes, every kind, zero divisor, equal moduli, unused kinds
    directed = '{
      mk(cacu_pkg::KIND_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000),
      mk(cacu_pkg::KIND_ADD, 32'h0001_0000, 32'hffff_0000, 32'h0002_0000, 32'h0000_8000),
      mk(cacu_pkg::KIND_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'hffff_ffff),
      mk(cacu_pkg::KIND_SUB, 32'h0, 32'h0, 32'h8000_0000, 32'h0),
      mk(cacu_pkg::KIND_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000),
      mk(cacu_pkg::KIND_MUL, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000),
      mk(cacu_pkg::KIND_MUL, 32'h0002_0000, 32'hfffe_8000, 32'hffff_0000, 32'h0000_0003),
      mk(cacu_pkg::KIND_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0),
      mk(cacu_pkg::KIND_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0000_0001),
      mk(cacu_pkg::KIND_DIV, 32'h0003_0000, 32'hffff_0000, 32'h0001_0000, 32'h0001_0000),
      mk(cacu_pkg::KIND_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000),
      mk(cacu_pkg::KIND_DIV, 32'hffff_ffff, 32'h1, 32'h7fff_ffff, 32'h7fff_ffff),
      mk(cacu_pkg::KIND_CMP, 32'h0003_0000, 32'h0004_0000, 32'h0005_0000, 32'h0),
      mk(cacu_pkg::KIND_CMP, 32'h0003_0000, 32'h0004_0000, 32'h0005_0042, 32'h0),
      mk(cacu_pkg::KIND_CMP, 32'h0003_0000, 32'h0004_0000, 32'h0004_ff00, 32'h0),
      mk(cacu_pkg::KIND_CMP, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0),
      mk(cacu_pkg::KIND_CMP, 32'h0, 32'h0, 32'h7fff_ffff, 32'h8000_0000),
      mk(3'd5, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff),
      mk(3'd7, 32'h8000_0000, 32'h1, 32'h0, 32'h0)
    };
    foreach (directed[i]) send_item(directed[i]);
    drain();

    // sender idles seldom, receiver often; zero tolerance
    write_epsilon(16'd0);
    in_idle_pct = 6;
    out_idle_pct = 85;
    repeat (200) send_item(rand_item());
    drain();

    // sender idles often, receiver seldom; widest tolerance
    write_epsilon(16'hffff);
    in_idle_pct = 85;
    out_idle_pct = 6;
    repeat (200) send_item(rand_item());
    drain();

    // no idling; random tolerance
    write_epsilon(16'($urandom_range(1, 600)));
    in_idle_pct = 0;
    out_idle_pct = 0;
    repeat (200) send_item(rand_item());
    drain();

    if (book.expected_results.size() != 0)
      book.report("results missing", book.expected_results.size(), 32'h0);
    if (book.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // run limit
  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
